// File: rtl/core/vmrw_pkg.sv
// ----------------------------------------------------------------------------
// vmrw_pkg
// Shared types and constants of the masked rectangle write unit.
// ----------------------------------------------------------------------------
package vmrw_pkg;

    localparam int DEF_MEM_WIDTH  = 1024;
    localparam int DEF_MEM_HEIGHT = 512;

    localparam int PIX_W      = 16;
    localparam int ADDR_OUT_W = 19;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    localparam int DX_W   = 10;
    localparam int DY_W   = 9;
    localparam int RW_W   = 11;
    localparam int RH_W   = 10;
    localparam int CCNT_W = 10;
    localparam int RCNT_W = 9;

    localparam logic [RW_W-1:0] COL_LIMIT = 11'd1024;
    localparam logic [RH_W-1:0] ROW_LIMIT = 10'd512;

    localparam logic [PIX_W-1:0] MASK_BIT = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_TOP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_TOP   = 3'd5;

    typedef struct packed {
        logic force_top;
        logic guard_top;
    } mask_cfg_t;

    typedef enum logic {
        VRAM_CLEAR,
        VRAM_RUN
    } vram_state_t;

endpackage

// File: rtl/core/vmrw_addr_gen.sv
// ----------------------------------------------------------------------------
// vmrw_addr_gen
// Configuration registers, rectangle counters and word address generation.
// ----------------------------------------------------------------------------
module vmrw_addr_gen
    import vmrw_pkg::*;
#(
    parameter int COL_W = 10,
    parameter int ROW_W = 9
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   advance,
    output logic [ROW_W+COL_W-1:0] addr,
    output logic                   last,
    output mask_cfg_t              masks
);

    localparam int CSUM_W = (COL_W > DX_W + 1) ? COL_W : DX_W + 1;
    localparam int RSUM_W = (ROW_W > DY_W + 1) ? ROW_W : DY_W + 1;

    logic [DX_W-1:0]   dest_x_reg;
    logic [DY_W-1:0]   dest_y_reg;
    logic [RW_W-1:0]   rect_width_reg;
    logic [RH_W-1:0]   rect_height_reg;
    logic              force_top_reg;
    logic              guard_top_reg;
    logic [CCNT_W-1:0] col_cnt_reg, col_cnt_next;
    logic [RCNT_W-1:0] row_cnt_reg, row_cnt_next;

    logic              cfg_hit;
    logic [RW_W-1:0]   w_eff;
    logic [RH_W-1:0]   h_eff;
    logic              col_wrap;
    logic              row_wrap;
    logic [CSUM_W-1:0] col_sum;
    logic [RSUM_W-1:0] row_sum;

    always_comb
    begin
        case (cfg_index)
            REG_DEST_X, REG_DEST_Y, REG_RECT_WIDTH,
            REG_RECT_HEIGHT, REG_FORCE_TOP, REG_GUARD_TOP: cfg_hit = cfg_wr_en;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg      <= '0;
            dest_y_reg      <= '0;
            rect_width_reg  <= RW_W'(1);
            rect_height_reg <= RH_W'(1);
            force_top_reg   <= 1'b0;
            guard_top_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEST_X:      dest_x_reg      <= cfg_wdata[DX_W-1:0];
                REG_DEST_Y:      dest_y_reg      <= cfg_wdata[DY_W-1:0];
                REG_RECT_WIDTH:  rect_width_reg  <= cfg_wdata[RW_W-1:0];
                REG_RECT_HEIGHT: rect_height_reg <= cfg_wdata[RH_W-1:0];
                REG_FORCE_TOP:   force_top_reg   <= cfg_wdata[0];
                REG_GUARD_TOP:   guard_top_reg   <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (rect_width_reg == '0)
            w_eff = RW_W'(1);
        else if (rect_width_reg > COL_LIMIT)
            w_eff = COL_LIMIT;
        else
            w_eff = rect_width_reg;

        if (rect_height_reg == '0)
            h_eff = RH_W'(1);
        else if (rect_height_reg > ROW_LIMIT)
            h_eff = ROW_LIMIT;
        else
            h_eff = rect_height_reg;

        col_wrap = (RW_W'(col_cnt_reg) + RW_W'(1)) >= w_eff;
        row_wrap = (RH_W'(row_cnt_reg) + RH_W'(1)) >= h_eff;

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_hit)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (advance)
        begin
            if (col_wrap)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_wrap ? '0 : row_cnt_reg + RCNT_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + CCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // power-of-two memory: wrap is a truncation
    assign col_sum = CSUM_W'(dest_x_reg) + CSUM_W'(col_cnt_reg);
    assign row_sum = RSUM_W'(dest_y_reg) + RSUM_W'(row_cnt_reg);
    assign addr    = {row_sum[ROW_W-1:0], col_sum[COL_W-1:0]};
    assign last    = col_wrap && row_wrap;

    assign masks.force_top = force_top_reg;
    assign masks.guard_top = guard_top_reg;

endmodule

// File: rtl/core/vmrw_vram.sv
// ----------------------------------------------------------------------------
// vmrw_vram
// Video memory, one read and one write port, registered read data.
// Sweeps every word to zero after reset.
// ----------------------------------------------------------------------------
module vmrw_vram
    import vmrw_pkg::*;
#(
    parameter int ADDR_W = 19
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    output logic              busy
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    vram_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [PIX_W-1:0]  mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= VRAM_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        busy          = 1'b0;
        mem_we        = wr_en;
        mem_waddr     = wr_addr;
        mem_wdata     = wr_data;
        case (state_reg)
            VRAM_CLEAR:
            begin
                busy          = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    state_next = VRAM_RUN;
            end
            VRAM_RUN:
            begin
                busy = 1'b0;
            end
            default:
            begin
                state_next = VRAM_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/vmrw_rmw.sv
// ----------------------------------------------------------------------------
// vmrw_rmw
// Modify stage: mask check, write back, forwarding of the last write,
// and the result register.
// ----------------------------------------------------------------------------
module vmrw_rmw
    import vmrw_pkg::*;
#(
    parameter int ADDR_W = 19
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [ADDR_W-1:0] in_addr,
    input  logic [PIX_W-1:0]  in_pix,
    input  logic              in_last,
    output logic              in_ready,
    input  mask_cfg_t         masks,
    input  logic [PIX_W-1:0]  rd_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [PIX_W-1:0]  wr_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] out_addr,
    output logic              out_written,
    output logic [PIX_W-1:0]  out_word,
    output logic              out_last
);

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic              s1_last_reg;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [PIX_W-1:0]  fwd_word_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_written_reg;
    logic [PIX_W-1:0]  out_word_reg;
    logic              out_last_reg;

    logic              s1_fire;
    logic [PIX_W-1:0]  old_word;
    logic              protect;
    logic [PIX_W-1:0]  new_word;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    // read issued in the same cycle as the previous write sees stale data
    assign old_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_word_reg
                                                                       : rd_data;
    assign protect  = masks.guard_top && ((old_word & MASK_BIT) != '0);
    assign new_word = protect ? old_word
                              : (s1_pix_reg | (masks.force_top ? MASK_BIT : '0));

    assign wr_en   = s1_fire && !protect;
    assign wr_addr = s1_addr_reg;
    assign wr_data = new_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (wr_en)
                fwd_valid_reg <= 1'b1;

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg <= in_addr;
            s1_pix_reg  <= in_pix;
            s1_last_reg <= in_last;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_word_reg <= new_word;
        end
        if (s1_fire)
        begin
            out_addr_reg    <= s1_addr_reg;
            out_written_reg <= !protect;
            out_word_reg    <= new_word;
            out_last_reg    <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_addr    = out_addr_reg;
    assign out_written = out_written_reg;
    assign out_word    = out_word_reg;
    assign out_last    = out_last_reg;

endmodule

// File: rtl/core/vram_masked_rect_write_unit.sv
// ----------------------------------------------------------------------------
// vram_masked_rect_write_unit
// Masked rectangle write of 16-bit pixels into a video memory.
//
//  channel  dir  bits      contents (low bit up)
//  s_axis   in   tdata 16  pixel_value
//  m_axis   out  tdata 40  memory_address[18:0], stored_word[34:19], zero pad
//                tuser 1   was_written
//                tlast 1   last_pixel
//  cfg      in   wdata 11  register index 0..5, write only
//
//  One pixel per cycle sustained while m_tready stays high; a pixel's
//  result is registered after the memory read, then modify and write back.
//  After reset all MEM_WIDTH*MEM_HEIGHT words (524288 by default) are
//  swept to zero; no pixel is taken meanwhile, config writes are.
//  A stalled output holds the modify stage; one more pixel is taken while
//  a result waits, then s_tready stays low until m_tready returns.
// ----------------------------------------------------------------------------
module vram_masked_rect_write_unit
    import vmrw_pkg::*;
#(
    parameter int MEM_WIDTH  = DEF_MEM_WIDTH,
    parameter int MEM_HEIGHT = DEF_MEM_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // pixel_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // memory_address, stored_word, pad
    output logic                  m_tuser,   // was_written
    output logic                  m_tlast,   // last_pixel
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int COL_W  = $clog2(MEM_WIDTH);
    localparam int ROW_W  = $clog2(MEM_HEIGHT);
    localparam int ADDR_W = COL_W + ROW_W;

    logic              in_fire;
    logic              rmw_ready;
    logic              vram_busy;
    logic [ADDR_W-1:0] gen_addr;
    logic              gen_last;
    mask_cfg_t         masks;
    logic [PIX_W-1:0]  rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic [ADDR_W-1:0] out_addr;
    logic              out_written;
    logic [PIX_W-1:0]  out_word;

    assign s_tready = rmw_ready && !vram_busy;
    assign in_fire  = s_tvalid && s_tready;

    vmrw_addr_gen #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_addr_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (in_fire),
        .addr      (gen_addr),
        .last      (gen_last),
        .masks     (masks)
    );

    vmrw_vram #(
        .ADDR_W (ADDR_W)
    ) u_vram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (gen_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (vram_busy)
    );

    vmrw_rmw #(
        .ADDR_W (ADDR_W)
    ) u_rmw (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_addr     (gen_addr),
        .in_pix      (s_tdata),
        .in_last     (gen_last),
        .in_ready    (rmw_ready),
        .masks       (masks),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_addr    (out_addr),
        .out_written (out_written),
        .out_word    (out_word),
        .out_last    (m_tlast)
    );

    assign m_tdata = {5'd0, out_word, ADDR_OUT_W'(out_addr)};
    assign m_tuser = out_written;

endmodule
